// ===== src/wph_pkg.sv =====
// shared types and constants for the wav header checker
package wph_pkg;

  // longest file accepted before the too-long flag sticks
  localparam logic [24:0] MAX_BYTES = 25'd16777216;
  localparam logic [24:0] MIN_BYTES = 25'd44;

  // chunk and file tags as read little-endian
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // header layout
  localparam logic [31:0] RIFF_TAG_END = 32'd4;
  localparam logic [31:0] RIFF_HDR_LEN = 32'd12;
  localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  // accepted format
  localparam logic [15:0] CODING_PCM = 16'd1;
  localparam logic [15:0] BITS_16 = 16'd16;
  localparam logic [15:0] MONO = 16'd1;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  // result packing
  localparam int OUT_BITS = 83;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    PH_RIFF,
    PH_HDR,
    PH_BODY,
    PH_PAD
  } phase_t;

  // one classified byte as queued for the parser
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [24:0] pos;   // file position after this byte
    logic        over;  // byte arrived past the length limit
  } byte_item_t;

endpackage

// ===== src/wph_front.sv =====
// front end: accepts bytes, tracks file position and the length limit
module wph_front import wph_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_last,
  input  logic       q_full,
  output logic       in_ready,
  output logic       q_push,
  output byte_item_t q_item
);

  logic [24:0] pos;
  logic [24:0] pos_next;
  logic        over;

  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;

  // position saturates at the limit, later bytes are flagged
  assign over = (pos >= MAX_BYTES);
  assign pos_next = over ? pos : pos + 25'd1;

  assign q_item = '{data: in_data, last: in_last, pos: pos_next, over: over};

  // restart counting after the last byte of a file
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (q_push) begin
      pos <= in_last ? '0 : pos_next;
    end
  end

endmodule

// ===== src/wph_queue.sv =====
// short queue of classified bytes between front and back
module wph_queue import wph_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  byte_item_t push_item,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output byte_item_t head
);

  byte_item_t        mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_AW:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == (Q_AW+1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;
  assign head = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end
  end

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH)) else $error("queue overfilled");

  // a pop on an empty queue leaves the read pointer alone
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |=> $stable(rd_ptr)) else $error("read pointer moved while empty");

  // a push into a full queue is refused
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> $stable(wr_ptr)) else $error("write into full queue");

endmodule

// ===== src/wph_back.sv =====
// back end: chunk parser and result register
module wph_back import wph_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  byte_item_t        q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_data
);

  phase_t      phase, phase_next;
  logic [31:0] cnt, cnt_next, cnt_inc;
  logic [63:0] shift, shift_next;
  logic [31:0] len, len_next;
  logic        is_fmt, is_fmt_next;
  logic        fmt_seen, fmt_seen_next;
  logic        data_seen, data_seen_next;
  logic [15:0] coding, coding_next;
  logic [15:0] channels, channels_next;
  logic [15:0] bits, bits_next;
  logic [31:0] rate, rate_next;
  logic [24:0] offset, offset_next;
  logic [31:0] hlen, hlen_next;
  logic        sticky, sticky_next;
  logic        ok;
  logic        out_free;
  logic        finish;

  // a final byte waits until the result register can take it
  assign out_free = !out_valid || out_ready;
  assign q_pop = q_valid && (!q_item.last || out_free);
  assign finish = q_pop && q_item.last;
  assign cnt_inc = cnt + 32'd1;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
      cnt <= '0;
      shift <= '0;
      len <= '0;
      is_fmt <= 1'b0;
      fmt_seen <= 1'b0;
      data_seen <= 1'b0;
      coding <= '0;
      channels <= '0;
      bits <= '0;
      rate <= '0;
      offset <= '0;
      hlen <= '0;
      sticky <= 1'b0;
    end else begin
      phase <= phase_next;
      cnt <= cnt_next;
      shift <= shift_next;
      len <= len_next;
      is_fmt <= is_fmt_next;
      fmt_seen <= fmt_seen_next;
      data_seen <= data_seen_next;
      coding <= coding_next;
      channels <= channels_next;
      bits <= bits_next;
      rate <= rate_next;
      offset <= offset_next;
      hlen <= hlen_next;
      sticky <= sticky_next;
    end
  end

  // next state for one byte
  always_comb begin
    phase_next = phase;
    cnt_next = cnt;
    shift_next = shift;
    len_next = len;
    is_fmt_next = is_fmt;
    fmt_seen_next = fmt_seen;
    data_seen_next = data_seen;
    coding_next = coding;
    channels_next = channels;
    bits_next = bits;
    rate_next = rate;
    offset_next = offset;
    hlen_next = hlen;
    sticky_next = sticky;
    ok = 1'b0;
    if (q_pop) begin
      sticky_next = sticky || q_item.over;
      shift_next = {q_item.data, shift[63:8]};
      case (phase)
        PH_RIFF: begin
          cnt_next = cnt_inc;
          if (cnt_inc == RIFF_TAG_END && shift_next[63:32] != TAG_RIFF) begin
            sticky_next = 1'b1;
          end
          if (cnt_inc == RIFF_HDR_LEN) begin
            if (shift_next[63:32] != TAG_WAVE) begin
              sticky_next = 1'b1;
            end
            phase_next = PH_HDR;
            cnt_next = '0;
          end
        end
        PH_HDR: begin
          cnt_next = cnt_inc;
          if (cnt_inc == CHUNK_HDR_LEN) begin
            len_next = shift_next[63:32];
            is_fmt_next = (shift_next[31:0] == TAG_FMT);
            cnt_next = '0;
            if (is_fmt_next) begin
              if (len_next < FMT_MIN_LEN) begin
                sticky_next = 1'b1;
              end
              fmt_seen_next = 1'b1;
            end else if (shift_next[31:0] == TAG_DATA) begin
              offset_next = q_item.pos;
              hlen_next = len_next;
              data_seen_next = (len_next != '0);
            end
            phase_next = (len_next != '0) ? PH_BODY : PH_HDR;
          end
        end
        PH_BODY: begin
          // fmt body fields, little-endian
          if (is_fmt) begin
            if (cnt == 32'd0) coding_next[7:0] = q_item.data;
            if (cnt == 32'd1) coding_next[15:8] = q_item.data;
            if (cnt == 32'd2) channels_next[7:0] = q_item.data;
            if (cnt == 32'd3) channels_next[15:8] = q_item.data;
            if (cnt == 32'd4) rate_next[7:0] = q_item.data;
            if (cnt == 32'd5) rate_next[15:8] = q_item.data;
            if (cnt == 32'd6) rate_next[23:16] = q_item.data;
            if (cnt == 32'd7) rate_next[31:24] = q_item.data;
            if (cnt == 32'd14) bits_next[7:0] = q_item.data;
            if (cnt == 32'd15) bits_next[15:8] = q_item.data;
          end
          cnt_next = cnt_inc;
          if (cnt_inc == len) begin
            cnt_next = '0;
            phase_next = len[0] ? PH_PAD : PH_HDR;
          end
        end
        default: begin
          phase_next = PH_HDR;
          cnt_next = '0;
        end
      endcase
      if (q_item.last) begin
        ok = !sticky_next && (q_item.pos >= MIN_BYTES) &&
             phase_next != PH_BODY && phase_next != PH_RIFF &&
             fmt_seen_next && data_seen_next &&
             coding_next == CODING_PCM && bits_next == BITS_16 &&
             channels_next == MONO && rate_next != '0 && !hlen_next[0];
        // back to reset for the next file
        phase_next = PH_RIFF;
        cnt_next = '0;
        shift_next = '0;
        len_next = '0;
        is_fmt_next = 1'b0;
        fmt_seen_next = 1'b0;
        data_seen_next = 1'b0;
        coding_next = '0;
        channels_next = '0;
        bits_next = '0;
        rate_next = '0;
        offset_next = '0;
        hlen_next = '0;
        sticky_next = 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result fields, zero when the file is turned down
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= OUT_W'({(ok ? hlen[24:0] : 25'd0), (ok ? offset : 25'd0),
                          (ok ? rate : 32'd0), ok});
    end
  end

  // a body is never empty and its count stays below the chunk length
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (len != '0 && cnt < len)) else $error("body count out of range");

  // the file header count never reaches its end while still in that phase
  a_riff_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RIFF) |-> (cnt < RIFF_HDR_LEN)) else $error("riff count out of range");

  // the final byte leaves the parser in its start state
  a_restart: assert property (@(posedge clk) disable iff (rst)
    finish |=> (phase == PH_RIFF && cnt == '0 && !sticky)) else $error("no restart after file");

  // a final byte is never consumed while a result is still held back
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !finish) else $error("result overwritten");

endmodule

// ===== src/wav_pcm16_mono_header_check.sv =====
// Top level of the streaming WAV header checker (PCM 16-bit mono).
// Throughput: one file byte per cycle, sustained, while the result side takes beats.
// Result: the last byte passes through the front-to-back queue and then the result register,
//   and it waits in the queue while the result side holds back an earlier beat.
// Reset: synchronous rst clears the position counter, queue, parser state and
//   result valid flag; s_tready is high as soon as the queue is cleared.
module wav_pcm16_mono_header_check import wph_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // file_byte[7:0]
  input  logic              s_tlast,   // final_byte
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // format_ok[0], rate_hz[32:1], pcm_offset[57:33],
                                       // pcm_bytes[82:58], zero fill above
);

  byte_item_t in_item;
  byte_item_t head;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_valid;

  // position tagging and length limit
  wph_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .q_full   (q_full),
    .in_ready (s_tready),
    .q_push   (q_push),
    .q_item   (in_item)
  );

  // decoupling queue
  wph_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (in_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  // chunk parser and result
  wph_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ===== tb/wav_pcm16_mono_header_check_tb.sv =====
// self-checking testbench for the streaming wav header checker
module wav_pcm16_mono_header_check_tb;
  import wph_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;

  // format values that must be turned down
  localparam logic [15:0] CODING_FLOAT = 16'd3;
  localparam logic [15:0] STEREO = 16'd2;
  localparam logic [15:0] BITS_8 = 16'd8;

  typedef enum int {
    CK_FMT,
    CK_DATA,
    CK_JUNK
  } chunk_kind_t;

  // result beat as packed on m_tdata, lowest field last
  typedef struct packed {
    logic [OUT_W-OUT_BITS-1:0] fill;
    logic [24:0]               pcm_bytes;
    logic [24:0]               pcm_offset;
    logic [31:0]               rate_hz;
    logic                      format_ok;
  } wav_verdict_t;

  // header parse model and queue of verdicts still owed
  class wav_header_scoreboard;
    phase_t       phase;
    logic [24:0]  byte_pos;
    logic [31:0]  phase_count;
    logic [63:0]  window;
    logic [31:0]  chunk_len;
    bit           in_fmt;
    bit           fmt_seen;
    bit           data_seen;
    bit           broken;
    logic [15:0]  coding;
    logic [15:0]  chans;
    logic [15:0]  bits;
    logic [31:0]  rate;
    logic [24:0]  data_offset;
    logic [31:0]  data_len;
    wav_verdict_t verdict_q[$];
    int           fails;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_RIFF;
      byte_pos = '0;
      phase_count = '0;
      window = '0;
      chunk_len = '0;
      in_fmt = 1'b0;
      fmt_seen = 1'b0;
      data_seen = 1'b0;
      broken = 1'b0;
      coding = '0;
      chans = '0;
      bits = '0;
      rate = '0;
      data_offset = '0;
      data_len = '0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // advance the parse by one accepted byte, owe a verdict on the final one
    function void note_byte(logic [7:0] b, logic final_mark);
      logic [31:0]  tag;
      wav_verdict_t v;
      if (byte_pos >= MAX_BYTES) broken = 1'b1;
      else byte_pos++;
      window = {b, window[63:8]};
      case (phase)
        PH_RIFF: begin
          phase_count++;
          if (phase_count == RIFF_TAG_END && window[63:32] != TAG_RIFF) broken = 1'b1;
          if (phase_count == RIFF_HDR_LEN) begin
            if (window[63:32] != TAG_WAVE) broken = 1'b1;
            phase = PH_HDR;
            phase_count = '0;
          end
        end
        PH_HDR: begin
          phase_count++;
          if (phase_count == CHUNK_HDR_LEN) begin
            tag = window[31:0];
            chunk_len = window[63:32];
            in_fmt = (tag == TAG_FMT);
            phase_count = '0;
            if (in_fmt) begin
              if (chunk_len < FMT_MIN_LEN) broken = 1'b1;
              fmt_seen = 1'b1;
            end else if (tag == TAG_DATA) begin
              data_offset = byte_pos;
              data_len = chunk_len;
              data_seen = (chunk_len != 0);
            end
            phase = (chunk_len != 0) ? PH_BODY : PH_HDR;
          end
        end
        PH_BODY: begin
          // fmt body: coding 0..1, channels 2..3, rate 4..7, sample bits 14..15
          if (in_fmt) begin
            if (phase_count < 2) coding[8*phase_count[0] +: 8] = b;
            else if (phase_count < 4) chans[8*phase_count[0] +: 8] = b;
            else if (phase_count < 8) rate[8*phase_count[1:0] +: 8] = b;
            else if (phase_count == 14 || phase_count == 15) bits[8*phase_count[0] +: 8] = b;
          end
          phase_count++;
          if (phase_count == chunk_len) begin
            phase_count = '0;
            phase = chunk_len[0] ? PH_PAD : PH_HDR;
          end
        end
        default: begin
          phase = PH_HDR;
          phase_count = '0;
        end
      endcase
      if (final_mark) begin
        v = '0;
        if (!broken && byte_pos >= MIN_BYTES && phase != PH_BODY && phase != PH_RIFF &&
            fmt_seen && data_seen && coding == CODING_PCM && bits == BITS_16 &&
            chans == MONO && rate != 0 && !data_len[0]) begin
          v.format_ok = 1'b1;
          v.rate_hz = rate;
          v.pcm_offset = data_offset;
          v.pcm_bytes = data_len[24:0];
        end
        verdict_q.push_back(v);
        clear();
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      fails++;
    endtask

    // compare a result beat with the oldest verdict owed
    task check_result(wav_verdict_t got);
      wav_verdict_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("result beat %h with no file end waiting", got));
        return;
      end
      want = verdict_q.pop_front();
      if (got.format_ok !== want.format_ok)
        report($sformatf("format_ok got %b want %b", got.format_ok, want.format_ok));
      if (got.rate_hz !== want.rate_hz)
        report($sformatf("rate_hz got %h want %h", got.rate_hz, want.rate_hz));
      if (got.pcm_offset !== want.pcm_offset)
        report($sformatf("pcm_offset got %h want %h", got.pcm_offset, want.pcm_offset));
      if (got.pcm_bytes !== want.pcm_bytes)
        report($sformatf("pcm_bytes got %h want %h", got.pcm_bytes, want.pcm_bytes));
      if (got.fill !== want.fill)
        report($sformatf("fill bits got %h, not zero", got.fill));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  logic             idle_on = 1'b1;
  logic             hold_ask = 1'b0;
  bit               hold_done = 1'b0;
  int               cycle_count = 0;
  logic [7:0]       wav_bytes[$];

  wav_header_scoreboard sb = new();

  wav_pcm16_mono_header_check i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // beat monitors on both sides
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_ask && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      m_tready <= !(idle_on && $urandom_range(99) < 12);
    end
  end

  // offer one byte, return at the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic mark);
    while (idle_on && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= mark;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_file();
    foreach (wav_bytes[i]) send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
    wav_bytes.delete();
  endtask

  // file building
  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) wav_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_riff();
    put_word(TAG_RIFF);
    put_word($urandom);
    put_word(TAG_WAVE);
  endfunction

  function automatic void put_chunk(logic [31:0] tag, logic [31:0] len, bit pad);
    put_word(tag);
    put_word(len);
    for (int unsigned i = 0; i < len; i++) wav_bytes.push_back(8'($urandom));
    if (len[0] && pad) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_fmt(logic [31:0] len, logic [15:0] coding, logic [15:0] chans,
                                  logic [31:0] rate, logic [15:0] bits, bit pad);
    logic [127:0] body;
    body = {bits, 48'({$urandom, $urandom}), rate, chans, coding};
    put_word(TAG_FMT);
    put_word(len);
    for (int unsigned i = 0; i < len; i++)
      wav_bytes.push_back(i < 16 ? body[8*i +: 8] : 8'($urandom));
    if (len[0] && pad) wav_bytes.push_back(8'($urandom));
  endfunction

  // plain mono pcm file with chosen rate and data length
  function automatic void put_plain(logic [31:0] rate, logic [31:0] dlen);
    put_riff();
    put_fmt(FMT_MIN_LEN, CODING_PCM, MONO, rate, BITS_16, 1'b1);
    put_chunk(TAG_DATA, dlen, 1'b1);
  endfunction

  function automatic logic [15:0] mostly(logic [15:0] usual);
    return ($urandom_range(99) < 90) ? usual : 16'($urandom_range(3) == 0 ? $urandom : usual + 1);
  endfunction

  // mostly well-formed files with random content, some noise and breakage
  function automatic void build_random_file();
    chunk_kind_t kinds[$];
    chunk_kind_t swap;
    int          roll;
    logic [31:0] len;
    kinds = '{CK_FMT, CK_DATA};
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 64)) wav_bytes.push_back(8'($urandom));
      return;
    end
    put_riff();
    if (roll < 14) begin
      roll = $urandom_range(7);
      wav_bytes[roll < 4 ? roll : roll + 4] ^= 8'(1 << $urandom_range(7));
    end
    if ($urandom_range(99) < 20) begin
      swap = kinds[0];
      kinds[0] = kinds[1];
      kinds[1] = swap;
    end
    if ($urandom_range(99) < 30) kinds.insert($urandom_range(2), CK_JUNK);
    if ($urandom_range(99) < 15) kinds.push_back($urandom_range(1) ? CK_FMT : CK_DATA);
    if ($urandom_range(99) < 6) kinds.delete($urandom_range(1));
    foreach (kinds[i]) begin
      roll = $urandom_range(99);
      case (kinds[i])
        CK_FMT: begin
          len = roll < 75 ? 16 : roll < 90 ? 18 : roll < 95 ? 17 : $urandom_range(15);
          put_fmt(len, mostly(CODING_PCM), mostly(MONO),
                  ($urandom_range(99) < 6) ? 32'd0 : 32'($urandom),
                  mostly(BITS_16), $urandom_range(9) != 0);
        end
        CK_DATA: begin
          len = roll < 5 ? 0 : roll < 10 ? 2 * $urandom_range(19) + 1 :
                roll < 13 ? 2 * $urandom_range(40, 200) : 2 * $urandom_range(1, 20);
          put_chunk(TAG_DATA, len, $urandom_range(9) != 0);
        end
        default: begin
          // a header claiming a body longer than the file
          if (roll < 5) begin
            put_word($urandom);
            put_word(32'($urandom) | 32'h100);
            repeat ($urandom_range(4)) wav_bytes.push_back(8'($urandom));
            return;
          end
          put_chunk($urandom, $urandom_range(20), $urandom_range(9) != 0);
        end
      endcase
    end
    // ragged endings: cut short or a trailing piece of a header
    roll = $urandom_range(99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 12)) if (wav_bytes.size() > 1) void'(wav_bytes.pop_back());
    end else if (roll < 20) begin
      repeat ($urandom_range(1, 7)) wav_bytes.push_back(8'($urandom));
    end
  endfunction

  initial begin
    int n_files;
    int n_bytes;
    n_files = 0;
    n_bytes = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // valid file, widest rate
    put_plain('1, 2);
    send_file();
    // valid, smallest rate, longer fmt body
    put_riff();
    put_fmt(18, CODING_PCM, MONO, 32'd1, BITS_16, 1'b1);
    put_chunk(TAG_DATA, 8, 1'b1);
    send_file();
    // one-byte file
    wav_bytes.push_back(8'hFF);
    send_file();
    // 43 bytes, ending in part of a header
    put_riff();
    put_fmt(FMT_MIN_LEN, CODING_PCM, MONO, 32'd44100, BITS_16, 1'b1);
    repeat (7) wav_bytes.push_back(8'h00);
    send_file();
    // wrong riff tag, wrong wave tag
    put_plain(32'd44100, 4);
    wav_bytes[0] ^= 8'h01;
    send_file();
    put_plain(32'd44100, 4);
    wav_bytes[11] ^= 8'h80;
    send_file();
    // fmt chunk too short
    put_riff();
    put_fmt(14, CODING_PCM, MONO, 32'd8000, BITS_16, 1'b1);
    put_chunk(TAG_DATA, 4, 1'b1);
    send_file();
    // data header as the last bytes, body never arrives
    put_riff();
    put_fmt(FMT_MIN_LEN, CODING_PCM, MONO, 32'd8000, BITS_16, 1'b1);
    put_word(TAG_DATA);
    put_word(32'h7FFF_FFFF);
    send_file();
    // trailing partial header is ignored
    put_plain(32'd8000, 6);
    repeat (5) wav_bytes.push_back(8'($urandom));
    send_file();
    // odd trailing chunk without its pad byte
    put_plain(32'd48000, 4);
    put_chunk($urandom, 3, 1'b0);
    send_file();
    // later empty data chunk wipes the earlier one
    put_plain(32'd22050, 4);
    put_chunk(TAG_DATA, 0, 1'b0);
    send_file();
    // stereo, 8-bit, float coding
    put_riff();
    put_fmt(FMT_MIN_LEN, CODING_PCM, STEREO, 32'd16000, BITS_16, 1'b1);
    put_chunk(TAG_DATA, 4, 1'b1);
    send_file();
    put_riff();
    put_fmt(FMT_MIN_LEN, CODING_PCM, MONO, 32'd16000, BITS_8, 1'b1);
    put_chunk(TAG_DATA, 4, 1'b1);
    send_file();
    put_riff();
    put_fmt(FMT_MIN_LEN, CODING_FLOAT, MONO, 32'd16000, BITS_16, 1'b1);
    put_chunk(TAG_DATA, 4, 1'b1);
    send_file();
    // zero rate, odd data length
    put_plain(32'd0, 4);
    send_file();
    put_plain(32'd16000, 5);
    send_file();
    // later fmt overrides a stereo one
    put_riff();
    put_fmt(FMT_MIN_LEN, CODING_PCM, STEREO, 32'd11025, BITS_16, 1'b1);
    put_chunk(TAG_DATA, 4, 1'b1);
    put_fmt(FMT_MIN_LEN, CODING_PCM, MONO, 32'h8000_0001, BITS_16, 1'b1);
    send_file();
    // odd junk body then data before fmt
    put_riff();
    put_chunk($urandom, 33, 1'b1);
    put_chunk(TAG_DATA, 32'h22, 1'b1);
    put_fmt(FMT_MIN_LEN, CODING_PCM, MONO, 32'd96000, BITS_16, 1'b1);
    send_file();
    // all-zero noise
    repeat (50) wav_bytes.push_back(8'h00);
    send_file();

    // random files
    while (n_files < 7 || n_bytes < 400) begin
      if (n_files == 1) hold_ask <= 1'b1;
      if (n_files == 4) begin
        // let every owed verdict drain before going on
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      idle_on <= !(n_files >= 4);
      build_random_file();
      n_bytes += wav_bytes.size();
      send_file();
      n_files++;
    end

    // drain and settle
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
    if (sb.fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
